[hw/rtl/ght_pkg.sv]
// shared types and constants of the generational handle table
package ght_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int OWNER_BITS = 16;
  localparam int GEN_BITS = 24;
  localparam int MEM_WIDTH = GEN_BITS + OWNER_BITS;
  localparam logic [7:0] HANDLE_TAG = 8'h45;
  localparam logic [GEN_BITS-1:0] GEN_MAX = {GEN_BITS{1'b1}};
  localparam logic [GEN_BITS-1:0] GEN_FIRST = GEN_BITS'(1);

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_LOOKUP  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_CHECK
  } state_t;

  // slot bookkeeping update issued at the end of an item
  typedef struct packed {
    logic                 valid;
    logic                 take;
    logic [SLOT_BITS-1:0] slot;
  } upd_t;

endpackage

[hw/rtl/generational_handle_table_unit.sv]
// top level of the generational handle table
//
// input channel: in_valid / in_stall with operation, handle and owner_id.
// a word is taken when in_valid is high and in_stall is low. create takes
// the lowest free slot for owner_id, destroy checks and frees a handle,
// lookup checks a handle without changing anything.
// output channel: out_valid / out_stall with status, issued_handle and
// slot_index, one result word for every input word, in order.
// timing: a word is taken in the idle state while the slot entry is read
// from the generation/owner ram, whose read is registered; the check cycle
// that follows checks it, writes back and loads the output register.
// the input is stalled during the check cycle; the next word can be taken
// while a finished result still sits in the output register.
// when the receiver stalls with a result pending, the check cycle holds
// until the output register frees, so backpressure reaches the input.
// reset (rst, synchronous) marks every slot free with generation 1 and
// empties the output register; no clearing pass is needed since per-slot
// flags stand in for the ram generation until a destroy first writes it.
module generational_handle_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] handle,
  input  logic [15:0] owner_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] issued_handle,
  output logic [5:0]  slot_index
);
  import ght_pkg::*;

  state_t state, state_next;

  // item captured at accept
  logic [1:0]            op;
  logic [GEN_BITS-1:0]   hgen;
  logic [OWNER_BITS-1:0] owner;
  logic [SLOT_BITS-1:0]  slot;
  logic                  pre_ok;
  logic                  full_at;

  logic                  accept;
  logic                  done;
  upd_t                  upd;
  logic                  occ_hit, genv_hit, full;
  logic [SLOT_BITS-1:0]  free_slot, slot_sel;
  logic                  mem_we;
  logic [MEM_WIDTH-1:0]  mem_wdata, mem_rdata;

  // handle decode
  logic [31:0]           h_low;
  logic [GEN_BITS-1:0]   h_gen;
  logic                  h_ok;

  // check results
  logic [GEN_BITS-1:0]   entry_gen, gen_bumped;
  logic [OWNER_BITS-1:0] entry_owner;
  logic                  live_match;
  logic [1:0]            status_next;
  logic [63:0]           issued_next;
  logic [5:0]            index_next;
  logic                  out_valid_next;

  assign h_low = handle[31:0];
  assign h_gen = handle[55:32];
  assign h_ok = (handle[63:56] == HANDLE_TAG) && (h_low != 32'd0) &&
                (h_gen != '0) && (h_low <= 32'(SLOT_COUNT));

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  // create reads the lowest free slot, the others the slot in the handle
  assign slot_sel = (op_t'(operation) == OP_CREATE) ? free_slot
                                                    : SLOT_BITS'(h_low - 32'd1);

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= operation;
      hgen <= h_gen;
      owner <= owner_id[OWNER_BITS-1:0];
      slot <= slot_sel;
      pre_ok <= h_ok;
      full_at <= full;
    end
  end

  ght_occ u_occ (
    .clk       (clk),
    .rst       (rst),
    .upd       (upd),
    .rd_slot   (slot),
    .occ_hit   (occ_hit),
    .genv_hit  (genv_hit),
    .full      (full),
    .free_slot (free_slot)
  );

  // generation and owner of each slot
  ght_ram #(
    .WIDTH (MEM_WIDTH),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (slot_sel),
    .rdata (mem_rdata)
  );

  // a never-destroyed slot still has its reset generation
  assign entry_gen = genv_hit ? mem_rdata[MEM_WIDTH-1:OWNER_BITS] : GEN_FIRST;
  assign entry_owner = mem_rdata[OWNER_BITS-1:0];
  assign gen_bumped = (entry_gen == GEN_MAX) ? GEN_FIRST : entry_gen + GEN_FIRST;
  assign live_match = pre_ok && occ_hit && (entry_gen == hgen) &&
                      (entry_owner == owner);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done = 1'b0;
    upd = '0;
    mem_we = 1'b0;
    mem_wdata = {entry_gen, owner};
    status_next = ST_INVALID;
    issued_next = '0;
    index_next = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // hold until the output register can take the result
        done = !out_valid || !out_stall;
        if (done) begin
          state_next = S_IDLE;
        end
        unique case (op)
          OP_CREATE: begin
            if (owner == '0) begin
              status_next = ST_INVALID;
            end else if (full_at) begin
              status_next = ST_FULL;
            end else begin
              status_next = ST_OK;
              issued_next = {HANDLE_TAG, entry_gen, 32'(slot) + 32'd1};
              index_next = 6'(slot);
              mem_we = done;
              mem_wdata = {entry_gen, owner};
              upd.valid = done;
              upd.take = 1'b1;
              upd.slot = slot;
            end
          end
          OP_DESTROY: begin
            if (live_match) begin
              status_next = ST_OK;
              index_next = 6'(slot);
              mem_we = done;
              mem_wdata = {gen_bumped, {OWNER_BITS{1'b0}}};
              upd.valid = done;
              upd.take = 1'b0;
              upd.slot = slot;
            end
          end
          OP_LOOKUP: begin
            if (live_match) begin
              status_next = ST_OK;
              index_next = 6'(slot);
            end
          end
          default: begin
            status_next = ST_INVALID;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_next = out_valid;
    if (done) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status <= status_next;
      issued_handle <= issued_next;
      slot_index <= index_next;
    end
  end

endmodule

[hw/rtl/ght_ram.sv]
// generic single-port-write ram with registered read
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/ght_occ.sv]
// occupancy and generation-written bits with lowest free slot search
module ght_occ (
  input  logic                          clk,
  input  logic                          rst,
  input  ght_pkg::upd_t                 upd,
  input  logic [ght_pkg::SLOT_BITS-1:0] rd_slot,
  output logic                          occ_hit,
  output logic                          genv_hit,
  output logic                          full,
  output logic [ght_pkg::SLOT_BITS-1:0] free_slot
);
  import ght_pkg::*;

  logic [SLOT_COUNT-1:0] occupied;
  logic [SLOT_COUNT-1:0] gen_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
      gen_valid <= '0;
    end else if (upd.valid) begin
      occupied[upd.slot] <= upd.take;
      // generation in ram is meaningful once a destroy has written it
      if (!upd.take) begin
        gen_valid[upd.slot] <= 1'b1;
      end
    end
  end

  assign occ_hit = occupied[rd_slot];
  assign genv_hit = gen_valid[rd_slot];
  assign full = &occupied;

  // lowest free slot wins
  always_comb begin
    free_slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!occupied[i]) begin
        free_slot = SLOT_BITS'(i);
      end
    end
  end

endmodule

[hw/rtl/ght_checker.sv]
// port-level checks of the generational handle table and their binding
module ght_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [63:0] issued_handle,
  input logic [5:0]  slot_index
);
  import ght_pkg::*;

  // output empties after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(issued_handle) && $stable(slot_index))
    else $error("stalled result word changed");

  // failed requests report zero handle and index
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (issued_handle == 64'd0) &&
      (slot_index == 6'd0))
    else $error("failure with nonzero handle or index");

  // issued handle carries the tag and names the reported slot
  a_handle_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) && (issued_handle != 64'd0) |->
      (issued_handle[63:56] == HANDLE_TAG) && (issued_handle[55:32] != 24'd0) &&
      (issued_handle[31:0] == 32'(slot_index) + 32'd1))
    else $error("malformed issued handle");

  // an accepted word is followed by a stall while it is checked
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in back-to-back cycles");

endmodule

bind generational_handle_table_unit ght_checker u_ght_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .issued_handle (issued_handle),
  .slot_index    (slot_index)
);

[dv/tb_generational_handle_table_unit.sv]
// self-checking testbench of the generational handle table unit
`timescale 1ns / 1ps

module tb_generational_handle_table_unit;
  import ght_pkg::*;

  // operation code that names no operation, must be rejected
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // watchdog in clock cycles, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // random words per idle/stall mix
  localparam int WORDS_PER_PHASE = 180;
  // cycles to wait after the last result for stray words
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    status_t     status;
    logic [63:0] issued;
    logic [5:0]  slot;
  } handle_result_t;

  // one row of the directed table; want only counts when fixed is set
  typedef struct packed {
    logic [1:0]     op;
    logic [63:0]    handle;
    logic [15:0]    owner;
    logic           fixed;
    handle_result_t want;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [63:0] handle;
  logic [15:0] owner_id;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [63:0] issued_handle;
  logic [5:0]  slot_index;

  // shadow copy of the slot table
  logic                slot_live  [SLOT_COUNT];
  logic [GEN_BITS-1:0] slot_gen   [SLOT_COUNT];
  logic [15:0]         slot_owner [SLOT_COUNT];

  // results still owed by the block, oldest first
  handle_result_t pending_results [$];
  handle_result_t got_res;
  handle_result_t want_res;

  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;
  int error_count;
  int words_sent;
  int results_checked;
  int n_create_ok;
  int n_destroy_ok;
  int n_lookup_ok;
  int n_full;
  int n_rejected;

  // after reset: slot 0 and 1 get taken, slot 0 is freed and reissued
  // with generation 2, slot 1 is freed again
  directed_row_t directed_rows [23] = '{
    // create without an owner
    '{OP_CREATE,  64'h0,                 16'h0000, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    '{OP_CREATE,  64'hffff_ffff_ffff_ffff, 16'h0001, 1'b1,
      '{ST_OK, 64'h4500_0001_0000_0001, 6'd0}},
    '{OP_CREATE,  64'h0,                 16'hffff, 1'b1,
      '{ST_OK, 64'h4500_0001_0000_0002, 6'd1}},
    '{OP_LOOKUP,  64'h4500_0001_0000_0001, 16'h0001, 1'b1, '{ST_OK, 64'h0, 6'd0}},
    // owner mismatch
    '{OP_LOOKUP,  64'h4500_0001_0000_0001, 16'h0002, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    // wrong tag
    '{OP_LOOKUP,  64'h4600_0001_0000_0001, 16'h0001, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    // zero index field
    '{OP_LOOKUP,  64'h4500_0001_0000_0000, 16'h0001, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    // zero generation field
    '{OP_LOOKUP,  64'h4500_0000_0000_0001, 16'h0001, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    // index one past the last slot
    '{OP_LOOKUP,  64'h4500_0001_0000_0041, 16'h0001, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    // largest index field
    '{OP_DESTROY, 64'h4500_0001_ffff_ffff, 16'h0001, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    // slot never taken
    '{OP_LOOKUP,  64'h4500_0001_0000_0003, 16'h0001, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    // generation mismatch
    '{OP_LOOKUP,  64'h4500_0002_0000_0001, 16'h0001, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    // unused operation with an otherwise live handle
    '{OP_UNUSED,  64'h4500_0001_0000_0001, 16'h0001, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    '{OP_DESTROY, 64'h4500_0001_0000_0001, 16'h0001, 1'b1, '{ST_OK, 64'h0, 6'd0}},
    // stale handle after destroy
    '{OP_DESTROY, 64'h4500_0001_0000_0001, 16'h0001, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    '{OP_LOOKUP,  64'h4500_0001_0000_0002, 16'hffff, 1'b1, '{ST_OK, 64'h0, 6'd1}},
    // freed slot comes back with the next generation
    '{OP_CREATE,  64'h0,                 16'h1234, 1'b1,
      '{ST_OK, 64'h4500_0002_0000_0001, 6'd0}},
    '{OP_DESTROY, 64'hffff_ffff_ffff_ffff, 16'hffff, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    '{OP_LOOKUP,  64'h0,                 16'h0000, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    '{OP_LOOKUP,  64'h4500_0001_0000_0002, 16'h0000, 1'b1, '{ST_INVALID, 64'h0, 6'd0}},
    '{OP_DESTROY, 64'h4500_0001_0000_0002, 16'hffff, 1'b1, '{ST_OK, 64'h0, 6'd1}},
    // last slot index, still free
    '{OP_LOOKUP,  64'h4500_0001_0000_0040, 16'h0000, 1'b0, '{ST_OK, 64'h0, 6'd0}},
    '{OP_CREATE,  64'h5555_aaaa_5555_aaaa, 16'h8000, 1'b0, '{ST_OK, 64'h0, 6'd0}}
  };

  generational_handle_table_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .handle       (handle),
    .owner_id     (owner_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .issued_handle(issued_handle),
    .slot_index   (slot_index)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor: applies one accepted word to the shadow table
  task automatic apply_table_op(input logic [1:0] op, input logic [63:0] h,
                                input logic [15:0] own, output handle_result_t res);
    logic [31:0]         low;
    logic [GEN_BITS-1:0] g;
    int                  free_slot;
    int                  idx;
    int                  i;
    bit                  hit;
    res  = '{ST_INVALID, 64'h0, 6'd0};
    low  = h[31:0];
    g    = h[55:32];
    idx  = 0;
    case (op)
      OP_CREATE: begin
        free_slot = -1;
        // lowest free slot wins
        for (i = SLOT_COUNT - 1; i >= 0; i--)
          if (!slot_live[i]) free_slot = i;
        if (own == 16'h0) begin
          res.status = ST_INVALID;
        end else if (free_slot < 0) begin
          res.status = ST_FULL;
        end else begin
          slot_live[free_slot]  = 1'b1;
          slot_owner[free_slot] = own;
          res.status = ST_OK;
          res.issued = {HANDLE_TAG, slot_gen[free_slot], 32'(free_slot + 1)};
          res.slot   = 6'(free_slot);
        end
      end
      OP_DESTROY, OP_LOOKUP: begin
        // decode, then range, occupancy, generation and owner
        hit = (h[63:56] == HANDLE_TAG) && (low != 32'h0) && (g != '0) &&
              (low <= 32'(SLOT_COUNT));
        if (hit) begin
          idx = int'(low) - 1;
          hit = slot_live[idx] && (slot_gen[idx] == g) && (slot_owner[idx] == own);
        end
        if (hit) begin
          res.status = ST_OK;
          res.slot   = 6'(idx);
          if (op == OP_DESTROY) begin
            slot_live[idx]  = 1'b0;
            slot_owner[idx] = 16'h0;
            slot_gen[idx]   = (slot_gen[idx] == GEN_MAX) ? GEN_FIRST : slot_gen[idx] + 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // owners cluster on a few values so handles often meet their owner
  function automatic logic [15:0] pick_owner();
    logic [15:0] own;
    case ($urandom_range(4))
      0: own = 16'h0001;
      1: own = 16'hffff;
      2: own = 16'h8000;
      default: own = 16'($urandom_range(16'hffff, 1));
    endcase
    return own;
  endfunction

  // random word: mostly live handles of their owner, some corrupted, some noise
  task automatic make_random_word(input int create_pct, output logic [1:0] op,
                                  output logic [63:0] h, output logic [15:0] own);
    int pick;
    int s;
    int start;
    int i;
    int tag_bit;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // noise over the whole input space, unused operation included
      op  = 2'($urandom_range(3));
      h   = {$urandom, $urandom};
      own = 16'($urandom_range(16'hffff));
    end else if (pick < 8 + create_pct) begin
      op  = OP_CREATE;
      h   = {$urandom, $urandom};
      own = ($urandom_range(99) < 4) ? 16'h0 : pick_owner();
    end else begin
      // aim at a live slot, a free one if the table is empty
      start = $urandom_range(SLOT_COUNT - 1);
      s     = start;
      for (i = 0; i < SLOT_COUNT; i++)
        if (!slot_live[s]) s = (s + 1) % SLOT_COUNT;
      op  = ($urandom_range(1) != 0) ? OP_DESTROY : OP_LOOKUP;
      h   = {HANDLE_TAG, slot_gen[s], 32'(s + 1)};
      own = slot_owner[s];
      if ($urandom_range(99) < 20) begin
        case ($urandom_range(5))
          0: own = own ^ (16'h1 << $urandom_range(15));
          1: h[55:32] = h[55:32] - 1'b1;
          2: begin
            tag_bit = $urandom_range(7);
            h[56 + tag_bit] = ~h[56 + tag_bit];
          end
          3: h[31:0] = 32'h0;
          4: h[31:0] = 32'($urandom_range(32'hffff_ffff, SLOT_COUNT + 1));
          default: h[55:32] = '0;
        endcase
      end
    end
  endtask

  // drive one word, hold it until taken, then log what the block owes
  task automatic send_word(input logic [1:0] op, input logic [63:0] h, input logic [15:0] own,
                           input logic fixed, input handle_result_t fixed_res);
    handle_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    operation <= op;
    handle    <= h;
    owner_id  <= own;
    do @(posedge clk); while (in_stall);
    apply_table_op(op, h, own, res);
    if (fixed) pending_results = {pending_results, fixed_res};
    else pending_results = {pending_results, res};
    words_sent++;
    if (res.status == ST_FULL) n_full++;
    else if (res.status != ST_OK) n_rejected++;
    else if (op == OP_CREATE) n_create_ok++;
    else if (op == OP_DESTROY) n_destroy_ok++;
    else n_lookup_ok++;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: mismatch at result %0d, %s: got %0h want %0h",
             results_checked, what, got, want);
    error_count++;
  endtask

  // receiver: check each taken result word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_res = '{status_t'(status), issued_handle, slot_index};
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing owed", issued_handle, 64'h0);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.status != want_res.status)
          report_mismatch("status", 64'(got_res.status), 64'(want_res.status));
        if (got_res.issued != want_res.issued)
          report_mismatch("issued_handle", got_res.issued, want_res.issued);
        if (got_res.slot != want_res.slot)
          report_mismatch("slot_index", 64'(got_res.slot), 64'(want_res.slot));
      end
      results_checked++;
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: timeout after %0d cycles, %0d results owed",
             cycle_count, pending_results.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [1:0]     op;
    logic [63:0]    h;
    logic [15:0]    own;
    handle_result_t no_res;
    int             phase;
    int             k;
    int             s;
    no_res         = '{ST_OK, 64'h0, 6'd0};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    words_sent     = 0;
    n_create_ok    = 0;
    n_destroy_ok   = 0;
    n_lookup_ok    = 0;
    n_full         = 0;
    n_rejected     = 0;
    // shadow table reset: all free, generation 1
    for (s = 0; s < SLOT_COUNT; s++) begin
      slot_live[s]  = 1'b0;
      slot_gen[s]   = GEN_FIRST;
      slot_owner[s] = 16'h0;
    end
    in_valid  <= 1'b0;
    operation <= OP_CREATE;
    handle    <= 64'h0;
    owner_id  <= 16'h0;
    rst       <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[r])
      send_word(directed_rows[r].op, directed_rows[r].handle, directed_rows[r].owner,
                directed_rows[r].fixed, directed_rows[r].want);

    // fill the table to the last slot, then run into the full case
    // (two slots are live already, so the last two creates find it full)
    repeat (SLOT_COUNT)
      send_word(OP_CREATE, {$urandom, $urandom}, 16'($urandom_range(16'hffff, 1)),
                1'b0, no_res);
    // full table with no owner still reports the missing owner
    send_word(OP_CREATE, 64'h0, 16'h0, 1'b0, no_res);
    // last slot: lookup and free it through its real handle
    send_word(OP_LOOKUP, {HANDLE_TAG, slot_gen[SLOT_COUNT-1], 32'(SLOT_COUNT)},
              slot_owner[SLOT_COUNT-1], 1'b0, no_res);
    send_word(OP_DESTROY, {HANDLE_TAG, slot_gen[SLOT_COUNT-1], 32'(SLOT_COUNT)},
              slot_owner[SLOT_COUNT-1], 1'b0, no_res);

    // generation wrap needs 2^24 - 1 destroys of one slot and stays out of reach

    // random part over four idle/stall mixes; each mix first grows the
    // table toward full, then drains it
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        make_random_word((k < WORDS_PER_PHASE * 3 / 5) ? 55 : 15, op, h, own);
        send_word(op, h, own, 1'b0, no_res);
      end
      // sender holds off until the block owes nothing
      if (phase == 1) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d words driven (directed, table fill, four idle/stall mixes), %0d checked",
             words_sent, results_checked);
    $display("tb: creates %0d, destroys %0d, lookups %0d passed; %0d full, %0d rejected",
             n_create_ok, n_destroy_ok, n_lookup_ok, n_full, n_rejected);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
